@@ src/qesm_pkg.sv @@
// Shared types and constants for the quadrature encoder speed meter.
// No dependencies; used by every other file of the block.
`default_nettype none

package qesm_pkg;

    localparam int TS_W      = 32;
    localparam int CNT_W     = 32;
    localparam int SPD_W     = 26;
    localparam int DIR_W     = 2;
    localparam int GEAR_W    = 10;
    localparam int CPR_W     = 12;
    localparam int RATIO_W   = GEAR_W + CPR_W;
    localparam int DEN_W     = TS_W + RATIO_W;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam int MUL_STEPS = RATIO_W;
    localparam int DIV_STEPS = SPD_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // 60 s * 1e6 us
    localparam logic [SPD_W-1:0] RPM_NUM = 26'd60000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIR  = 2'd0,
        CFG_GEAR = 2'd1,
        CFG_CPR  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

`default_nettype wire

@@ src/qesm_if.sv @@
// Valid/ready channel interfaces for event beats and result beats.
// Depends on qesm_pkg for field widths.
`default_nettype none

interface qesm_evt_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [qesm_pkg::TS_W-1:0]    timestamp_us;
    logic                         level_a;
    logic                         level_b;

    modport source (output valid, func, timestamp_us, level_a, level_b, input ready);
    modport sink   (input valid, func, timestamp_us, level_a, level_b, output ready);
endinterface

interface qesm_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [qesm_pkg::CNT_W-1:0] position_count;
    logic [qesm_pkg::TS_W-1:0]        period_us;
    logic [qesm_pkg::SPD_W-1:0]       speed_rpm;

    modport source (output valid, position_count, period_us, speed_rpm, input ready);
    modport sink   (input valid, position_count, period_us, speed_rpm, output ready);
endinterface

`default_nettype wire

@@ src/quadrature_encoder_speed_meter_unit.sv @@
// Each accepted event passes S_LOAD, the serial multiplier (S_MUL) and the serial
// divider (S_DIV) in order; S_HOLD waits while the output register is still full.
// One item in flight at a time: a new event is taken only back in S_IDLE.
// A finished result waits in the output register while the next event is taken.
// Reset (synchronous, active low): count, period and edge time cleared,
// direction sign, gear ratio and counts per rev set to 1. No clearing pass.
`default_nettype none

module quadrature_encoder_speed_meter_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    qesm_evt_if.sink                             i_evt,
    qesm_res_if.source                           o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [qesm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [qesm_pkg::CFG_W-1:0]      i_cfg_data
);
    import qesm_pkg::*;

    t_state             r_state, n_state;
    logic [DIR_W-1:0]   r_dir;
    logic [GEAR_W-1:0]  r_gear;
    logic [CPR_W-1:0]   r_cpr;
    logic [RATIO_W-1:0] ratio;

    logic               r_out_valid, n_out_valid;
    logic [CNT_W-1:0]   r_out_count;
    logic [TS_W-1:0]    r_out_period;
    logic [SPD_W-1:0]   r_out_speed;

    logic               in_acc;
    logic               out_acc;
    logic               mul_start;
    logic               div_start;
    logic               out_load;

    logic [CNT_W-1:0]   count;
    logic [TS_W-1:0]    period;
    logic [DEN_W-1:0]   den;
    logic [SPD_W-1:0]   quo;
    t_unit_sts          mul_sts;
    t_unit_sts          div_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIR_W'(1);
            r_gear <= GEAR_W'(1);
            r_cpr  <= CPR_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DIR:  r_dir  <= i_cfg_data[DIR_W-1:0];
                CFG_GEAR: r_gear <= i_cfg_data[GEAR_W-1:0];
                CFG_CPR:  r_cpr  <= i_cfg_data[CPR_W-1:0];
                default: ;
            endcase
        end
    end

    assign ratio = r_gear * r_cpr;

    assign i_evt.ready = (r_state == S_IDLE);
    assign in_acc      = i_evt.valid && i_evt.ready;
    assign out_acc     = r_out_valid && o_res.ready;

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                mul_start = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                if (mul_sts.done) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    if (!r_out_valid || o_res.ready) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (out_acc) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        if (out_load) begin
            r_out_count  <= count;
            r_out_period <= period;
            r_out_speed  <= quo;
        end
    end

    qesm_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_acc),
        .i_func   (i_evt.func),
        .i_ts     (i_evt.timestamp_us),
        .i_a      (i_evt.level_a),
        .i_b      (i_evt.level_b),
        .i_dir    (r_dir),
        .o_count  (count),
        .o_period (period)
    );

    qesm_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_period (period),
        .i_ratio  (ratio),
        .o_prod   (den),
        .o_sts    (mul_sts)
    );

    qesm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_den    (den),
        .o_quo    (quo),
        .o_sts    (div_sts)
    );

    assign o_res.valid          = r_out_valid;
    assign o_res.position_count = r_out_count;
    assign o_res.period_us      = r_out_period;
    assign o_res.speed_rpm      = r_out_speed;

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_evt.ready)
        else $error("event beat taken while an item is in flight");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_sts.busy && div_sts.busy))
        else $error("multiplier and divider busy together");

    a_mul_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_sts.done |=> div_sts.busy)
        else $error("divider not started after product");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.speed_rpm <= RPM_NUM))
        else $error("speed above numerator");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> ($past(r_state) == S_DIV || $past(r_state) == S_HOLD))
        else $error("result beat raised outside completion");
`endif

endmodule

`default_nettype wire

@@ src/qesm_track.sv @@
// Position count and edge period state, updated once per accepted event.
// Depends on qesm_pkg.
`default_nettype none

module qesm_track (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire logic                         i_func,
    input  wire logic [qesm_pkg::TS_W-1:0]    i_ts,
    input  wire logic                         i_a,
    input  wire logic                         i_b,
    input  wire logic [qesm_pkg::DIR_W-1:0]   i_dir,
    output logic      [qesm_pkg::CNT_W-1:0]   o_count,
    output logic      [qesm_pkg::TS_W-1:0]    o_period
);
    import qesm_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic [TS_W-1:0]  r_last,  n_last;
    logic [TS_W-1:0]  r_period, n_period;
    logic [CNT_W-1:0] step;

    assign step = {{(CNT_W-DIR_W){i_dir[DIR_W-1]}}, i_dir};

    always_comb begin
        n_count  = r_count;
        n_last   = r_last;
        n_period = r_period;
        if (i_load) begin
            if (i_func) begin
                n_count = '0;
            end else begin
                if (r_last < i_ts) begin
                    n_period = i_ts - r_last;
                end
                n_last = i_ts;
                if (i_a && !i_b) begin
                    n_count = r_count - step;
                end else begin
                    n_count = r_count + step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_last   <= '0;
            r_period <= '0;
        end else begin
            r_count  <= n_count;
            r_last   <= n_last;
            r_period <= n_period;
        end
    end

    assign o_count  = r_count;
    assign o_period = r_period;

endmodule

`default_nettype wire

@@ src/qesm_mul.sv @@
// Bit-serial shift-add multiplier: period times (gear ratio * counts per rev).
// One multiplier bit per cycle. Depends on qesm_pkg.
`default_nettype none

module qesm_mul (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [qesm_pkg::TS_W-1:0]      i_period,
    input  wire logic [qesm_pkg::RATIO_W-1:0]   i_ratio,
    output logic      [qesm_pkg::DEN_W-1:0]     o_prod,
    output qesm_pkg::t_unit_sts                 o_sts
);
    import qesm_pkg::*;

    logic [DEN_W-1:0]     r_acc, n_acc;
    logic [DEN_W-1:0]     r_mcand, n_mcand;
    logic [RATIO_W-1:0]   r_mplier, n_mplier;
    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_start) begin
            n_acc    = '0;
            n_mcand  = {{(DEN_W-TS_W){1'b0}}, i_period};
            n_mplier = i_ratio;
            n_cnt    = '0;
            n_busy   = 1'b1;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = {r_mcand[DEN_W-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[RATIO_W-1:1]};
            n_cnt    = r_cnt + 1'b1;
            if (r_cnt == MUL_CNT_W'(MUL_STEPS-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_prod     = r_acc;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

`default_nettype wire

@@ src/qesm_div.sv @@
// Radix-2 restoring divider: fixed rpm numerator over the 54-bit denominator.
// One quotient bit per cycle; zero denominator gives zero. Depends on qesm_pkg.
`default_nettype none

module qesm_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [qesm_pkg::DEN_W-1:0]   i_den,
    output logic      [qesm_pkg::SPD_W-1:0]   o_quo,
    output qesm_pkg::t_unit_sts               o_sts
);
    import qesm_pkg::*;

    logic [SPD_W:0]       r_den, n_den;
    logic                 r_den_big, n_den_big;
    logic                 r_den_zero, n_den_zero;
    logic [SPD_W-1:0]     r_rem, n_rem;
    logic [SPD_W-1:0]     r_quo, n_quo;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [SPD_W:0]       trial;
    logic [SPD_W:0]       diff;
    logic                 ge;

    assign trial = {r_rem, r_quo[SPD_W-1]};
    assign diff  = trial - r_den;
    assign ge    = !r_den_big && (trial >= r_den);

    always_comb begin
        n_den      = r_den;
        n_den_big  = r_den_big;
        n_den_zero = r_den_zero;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        n_busy     = r_busy;
        n_done     = 1'b0;
        if (i_start) begin
            n_den      = i_den[SPD_W:0];
            n_den_big  = |i_den[DEN_W-1:SPD_W+1];
            n_den_zero = (i_den == '0);
            n_rem      = '0;
            n_quo      = RPM_NUM;
            n_cnt      = '0;
            n_busy     = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? diff[SPD_W-1:0] : trial[SPD_W-1:0];
            n_quo = {r_quo[SPD_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_den      <= n_den;
        r_den_big  <= n_den_big;
        r_den_zero <= n_den_zero;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
    end

    assign o_quo      = r_den_zero ? '0 : r_quo;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

`default_nettype wire
